>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property shapes for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/cewrr_pkg.sv
// ----------------------------------------------------------------------------
// cewrr_pkg
// shared types, codes and sizes of the coalescing event queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cewrr_pkg;

  localparam int STICKS           = 4;
  localparam int STICK_IDX_W      = 2;
  localparam int FIFO_DEPTH_DEF   = 16;
  localparam int BUTTON_SLOTS_DEF = 2;
  localparam int ID_W             = 8;
  localparam int VAL_W            = 16;
  localparam int OP_W             = 2;
  localparam int STATUS_W         = 3;
  localparam int CFG_INDEX_W      = 3;

  typedef logic [ID_W-1:0]         id_t;
  typedef logic signed [VAL_W-1:0] value_t;

  typedef struct packed {
    id_t    id;
    value_t value;
  } entry_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] ST_PUSHED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/cewrr_cfg.sv
// ----------------------------------------------------------------------------
// cewrr_cfg
// stick id registers written through the configuration channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cewrr_cfg (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [cewrr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  cewrr_pkg::id_t                         cfg_data,
  output cewrr_pkg::id_t [cewrr_pkg::STICKS-1:0] stick_ids
);
  import cewrr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STICKS; k++) begin
        stick_ids[k] <= ID_W'(k);
      end
    end else if (cfg_valid && (cfg_index < CFG_INDEX_W'(STICKS))) begin
      stick_ids[cfg_index[STICK_IDX_W-1:0]] <= cfg_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cewrr_fifo.sv
// ----------------------------------------------------------------------------
// cewrr_fifo
// button event fifo with a registered read of the head entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cewrr_fifo #(
  parameter int DEPTH = cewrr_pkg::FIFO_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cewrr_pkg::fifo_ctrl_t ctrl,
  input  cewrr_pkg::entry_t     wr_data,
  output cewrr_pkg::entry_t     rd_data,
  output cewrr_pkg::fifo_stat_t stat
);
  import cewrr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= wr_data;
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (ctrl.push) begin
      tail  <= wrap_inc(tail);
      count <= count + 1'b1;
    end else if (ctrl.pop) begin
      head  <= wrap_inc(head);
      count <= count - 1'b1;
    end
  end

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

>>> hw/rtl/coalescing_event_queue_wrr_core.sv
// ----------------------------------------------------------------------------
// coalescing_event_queue_wrr_core
// gamepad event merger: stick events coalesce, button events queue, pops
// are served round robin over the sticks and the button slots
//
//   channel | handshake            | word
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall  | operation, event_id, event_value
//   out     | out_valid / out_stall| status, out_id, out_value, still_pending
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word at a time; a push compares the id with one stick per cycle on
// a shared comparator, a pop checks one slot per cycle from the rotating
// pointer, clear and no-op go straight to the finish state
// sync reset clears flags, fifo pointers and the slot pointer; no sweep
// in_stall is high from acceptance until the result sits in the output
// register; a stalled output holds its word and the block waits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module coalescing_event_queue_wrr_core #(
  parameter int FIFO_DEPTH   = cewrr_pkg::FIFO_DEPTH_DEF,
  parameter int BUTTON_SLOTS = cewrr_pkg::BUTTON_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cewrr_pkg::OP_W-1:0]         operation,
  input  logic [cewrr_pkg::ID_W-1:0]         event_id,
  input  logic signed [cewrr_pkg::VAL_W-1:0] event_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cewrr_pkg::STATUS_W-1:0]     status,
  output logic [cewrr_pkg::ID_W-1:0]         out_id,
  output logic signed [cewrr_pkg::VAL_W-1:0] out_value,
  output logic                               still_pending,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cewrr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cewrr_pkg::ID_W-1:0]         cfg_data
);
  import cewrr_pkg::*;

  localparam int SLOT_COUNT = STICKS + BUTTON_SLOTS;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                      state;
  id_t [STICKS-1:0]            stick_ids;
  value_t [STICKS-1:0]         stick_value;
  logic [STICKS-1:0]           stick_pending;
  id_t                         id_r;
  value_t                      val_r;
  logic [SLOT_W-1:0]           cursor;
  logic [SLOT_W-1:0]           steps;
  logic [SLOT_W-1:0]           slot_pointer;
  logic [STATUS_W-1:0]         res_status;
  id_t                         res_id;
  value_t                      res_value;
  logic [STICK_IDX_W-1:0]      k;
  logic                        id_hit;
  logic                        last_stick;
  logic                        on_stick;
  logic                        scan_hit;
  logic                        accept;
  fifo_ctrl_t                  fifo_ctrl;
  fifo_stat_t                  fifo_stat;
  entry_t                      fifo_rd;
  entry_t                      fifo_wr;

  cewrr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stick_ids (stick_ids)
  );

  cewrr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (fifo_ctrl),
    .wr_data (fifo_wr),
    .rd_data (fifo_rd),
    .stat    (fifo_stat)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  // shared compare unit, one stick or slot per cycle
  assign k          = cursor[STICK_IDX_W-1:0];
  assign id_hit     = (stick_ids[k] == id_r);
  assign last_stick = (k == STICK_IDX_W'(STICKS - 1));
  assign on_stick   = (cursor < SLOT_W'(STICKS));
  assign scan_hit   = on_stick ? stick_pending[k] : !fifo_stat.empty;

  assign fifo_wr.id    = id_r;
  assign fifo_wr.value = val_r;

  always_comb begin
    fifo_ctrl.push  = (state == S_MATCH) && !id_hit && last_stick && !fifo_stat.full;
    fifo_ctrl.pop   = (state == S_SCAN) && !on_stick && !fifo_stat.empty;
    fifo_ctrl.clear = accept && (op_t'(operation) == OP_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      stick_pending <= '0;
      stick_value   <= '0;
      slot_pointer  <= '0;
    end else begin
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            id_r      <= event_id;
            val_r     <= event_value;
            res_id    <= '0;
            res_value <= '0;
            steps     <= '0;
            cursor    <= '0;
            unique case (op_t'(operation))
              OP_PUSH: begin
                state <= S_MATCH;
              end
              OP_POP: begin
                cursor <= slot_pointer;
                state  <= S_SCAN;
              end
              OP_CLEAR: begin
                stick_pending <= '0;
                stick_value   <= '0;
                res_status    <= ST_CLEARED;
                state         <= S_FINISH;
              end
              default: begin
                res_status <= ST_NONE;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        S_MATCH: begin
          if (id_hit) begin
            stick_value[k]   <= val_r;
            stick_pending[k] <= 1'b1;
            res_status       <= ST_PUSHED;
            state            <= S_FINISH;
          end else if (last_stick) begin
            res_status <= fifo_stat.full ? ST_DROPPED : ST_PUSHED;
            state      <= S_FINISH;
          end else begin
            cursor <= cursor + 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            if (on_stick) begin
              stick_pending[k] <= 1'b0;
              res_id           <= stick_ids[k];
              res_value        <= stick_value[k];
            end else begin
              res_id    <= fifo_rd.id;
              res_value <= fifo_rd.value;
            end
            slot_pointer <= (cursor == SLOT_W'(SLOT_COUNT - 1)) ? '0 : cursor + 1'b1;
            res_status   <= ST_POPPED;
            state        <= S_FINISH;
          end else if (steps == SLOT_W'(SLOT_COUNT - 1)) begin
            res_status <= ST_NONE;
            state      <= S_FINISH;
          end else begin
            cursor <= (cursor == SLOT_W'(SLOT_COUNT - 1)) ? '0 : cursor + 1'b1;
            steps  <= steps + 1'b1;
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            out_id        <= res_id;
            out_value     <= res_value;
            still_pending <= (|stick_pending) || !fifo_stat.empty;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cewrr_checker.sv
// ----------------------------------------------------------------------------
// cewrr_checker
// port-level checks of the coalescing event queue, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cewrr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [cewrr_pkg::STATUS_W-1:0]     status,
  input logic [cewrr_pkg::ID_W-1:0]         out_id,
  input logic signed [cewrr_pkg::VAL_W-1:0] out_value,
  input logic                               still_pending
);
  import cewrr_pkg::*;

  // stalled result word holds
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(out_id) && $stable(out_value) && $stable(still_pending))
  // one word at a time
  `ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // only a pop carries an event
  `ASSERT_IMP(a_zero_unless_popped, clk, rst, out_valid && (status != ST_POPPED), (out_id == '0) && (out_value == '0))
  // a clear leaves nothing behind
  `ASSERT_IMP(a_clear_empties, clk, rst, out_valid && (status == ST_CLEARED), !still_pending)

endmodule

bind coalescing_event_queue_wrr_core cewrr_checker u_checker (.*);

`default_nettype wire
